[hdl/scan_longest_cluster_locator_macros.svh]
// Assertion macros shared by the cluster locator RTL.
// No dependencies; included inside module bodies.
`ifndef SCAN_LONGEST_CLUSTER_LOCATOR_MACROS_SVH
`define SCAN_LONGEST_CLUSTER_LOCATOR_MACROS_SVH

// Check cons in the same cycle as ante.
`define SLCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define SLCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/slcl_pkg.sv]
// Package for the longest cluster locator: types, constants, arctangent table.
// No dependencies.
`timescale 1ns / 1ps
package slcl_pkg;

   // Fixed-point constants (Q16 angles, Q30 sine)
   localparam logic signed [19:0] ANGLE_LIMIT     = 20'sd411774;
   localparam logic signed [20:0] PI_Q16          = 21'sd205887;
   localparam logic signed [20:0] HALF_PI_Q16     = 21'sd102944;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [18:0] DIST_LIMIT      = 19'sd65535;

   // Register reset values
   localparam logic [15:0]        MIN_RANGE_RESET   = 16'd300;
   localparam logic [15:0]        MAX_RANGE_RESET   = 16'd1000;
   localparam logic signed [19:0] START_ANGLE_RESET = -20'sd205887;
   localparam logic signed [19:0] ANGLE_STEP_RESET  = 20'sd572;

   // Register map
   typedef enum logic [3:0] {
      CSR_MIN_RANGE   = 4'd0,
      CSR_MAX_RANGE   = 4'd1,
      CSR_START_ANGLE = 4'd2,
      CSR_ANGLE_STEP  = 4'd3
   } csr_index_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_START,
      ST_DIV,
      ST_AMUL,
      ST_ASAT,
      ST_SINE_GO,
      ST_SINE,
      ST_DMUL,
      ST_DSAT,
      ST_FIN
   } state_type;

   // Commands from the sequencer to the scan tracker
   typedef struct packed {
      logic close;
      logic clear;
   } tracker_cmd_type;

   // Rounded Q30 arctangent of 2^-i
   function automatic logic [31:0] atan_q30(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:  val = 32'd843314857;
         5'd1:  val = 32'd497837829;
         5'd2:  val = 32'd263043837;
         5'd3:  val = 32'd133525159;
         5'd4:  val = 32'd67021687;
         5'd5:  val = 32'd33543516;
         5'd6:  val = 32'd16775851;
         5'd7:  val = 32'd8388437;
         5'd8:  val = 32'd4194283;
         5'd9:  val = 32'd2097149;
         5'd10: val = 32'd1048576;
         5'd11: val = 32'd524288;
         5'd12: val = 32'd262144;
         5'd13: val = 32'd131072;
         5'd14: val = 32'd65536;
         5'd15: val = 32'd32768;
         5'd16: val = 32'd16384;
         5'd17: val = 32'd8192;
         5'd18: val = 32'd4096;
         5'd19: val = 32'd2048;
         5'd20: val = 32'd1024;
         5'd21: val = 32'd512;
         5'd22: val = 32'd256;
         5'd23: val = 32'd128;
         default: val = 32'd0;
      endcase
      return val;
   endfunction

endpackage

[hdl/slcl_req_if.sv]
// Sample channel of the cluster locator: valid/ready plus one range sample.
// No dependencies.
`timescale 1ns / 1ps
interface slcl_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] sample_range;
   logic        sample_valid;
   logic        last_sample;

   modport source (output valid, sample_range, sample_valid, last_sample, input ready);
   modport sink   (input valid, sample_range, sample_valid, last_sample, output ready);
endinterface

[hdl/slcl_rsp_if.sv]
// Result channel of the cluster locator: valid/ready plus one cluster summary.
// No dependencies.
`timescale 1ns / 1ps
interface slcl_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic [15:0]        mean_range;
   logic signed [19:0] cluster_angle;
   logic signed [16:0] forward_distance;
   logic               truncated;

   modport source (output valid, found, mean_range, cluster_angle, forward_distance,
                   truncated, input ready);
   modport sink   (input valid, found, mean_range, cluster_angle, forward_distance,
                   truncated, output ready);
endinterface

[hdl/slcl_csr_if.sv]
// Register write channel of the cluster locator: valid/ready, index and data.
// No dependencies.
`timescale 1ns / 1ps
interface slcl_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [19:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/slcl_scan_tracker.sv]
// Per-sample range gate and run tracking; keeps the first longest run.
// Depends on slcl_pkg.
`timescale 1ns / 1ps
module slcl_scan_tracker #(
   parameter int MAX_SAMPLES = 2048,
   parameter int RANGE_W     = 16,
   parameter int IDX_W       = $clog2(MAX_SAMPLES + 1),
   parameter int SUM_W       = RANGE_W + IDX_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      sample_accept,
   input  logic [RANGE_W-1:0]        sample_range,
   input  logic                      sample_valid,
   input  logic [15:0]               min_range,
   input  logic [15:0]               max_range,
   input  slcl_pkg::tracker_cmd_type cmd,
   output logic [IDX_W-1:0]          best_start,
   output logic [IDX_W-1:0]          best_end,
   output logic [IDX_W-1:0]          best_length,
   output logic [SUM_W-1:0]          best_sum,
   output logic                      overflow
);
   import slcl_pkg::*;

   logic             prev_ff, prev_in;
   logic             overflow_ff, overflow_in;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [IDX_W-1:0] run_start_ff, run_start_in;
   logic [SUM_W-1:0] run_sum_ff, run_sum_in;
   logic [IDX_W-1:0] best_start_ff, best_start_in;
   logic [IDX_W-1:0] best_end_ff, best_end_in;
   logic [IDX_W-1:0] best_len_ff, best_len_in;
   logic [SUM_W-1:0] best_sum_ff, best_sum_in;

   logic             in_range;
   logic             in_window;
   logic             do_close;
   logic [IDX_W-1:0] run_len;

   // Gate the sample and decide whether a run ends here
   always_comb begin
      in_range  = sample_valid && (16'(sample_range) >= min_range) &&
                  (16'(sample_range) <= max_range);
      in_window = index_ff < IDX_W'(MAX_SAMPLES);
      run_len   = index_ff - run_start_ff;
      do_close  = prev_ff && ((sample_accept && in_window && !in_range) || cmd.close);
   end

   // Advance run state
   always_comb begin
      prev_in       = prev_ff;
      overflow_in   = overflow_ff;
      index_in      = index_ff;
      run_start_in  = run_start_ff;
      run_sum_in    = run_sum_ff;
      best_start_in = best_start_ff;
      best_end_in   = best_end_ff;
      best_len_in   = best_len_ff;
      best_sum_in   = best_sum_ff;
      if (sample_accept) begin
         if (in_window) begin
            if (in_range) begin
               if (!prev_ff) begin
                  run_start_in = index_ff;
                  run_sum_in   = SUM_W'(sample_range);
               end else begin
                  run_sum_in = run_sum_ff + SUM_W'(sample_range);
               end
            end
            prev_in  = in_range;
            index_in = index_ff + 1'b1;
         end else begin
            overflow_in = 1'b1;
         end
      end
      // Keep only a strictly longer run so the earliest wins ties
      if (do_close && (run_len > best_len_ff)) begin
         best_start_in = run_start_ff;
         best_end_in   = index_ff;
         best_len_in   = run_len;
         best_sum_in   = run_sum_ff;
      end
      if (cmd.clear) begin
         prev_in       = 1'b0;
         overflow_in   = 1'b0;
         index_in      = '0;
         run_start_in  = '0;
         run_sum_in    = '0;
         best_start_in = '0;
         best_end_in   = '0;
         best_len_in   = '0;
         best_sum_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= 1'b0;
         overflow_ff   <= 1'b0;
         index_ff      <= '0;
         run_start_ff  <= '0;
         run_sum_ff    <= '0;
         best_start_ff <= '0;
         best_end_ff   <= '0;
         best_len_ff   <= '0;
         best_sum_ff   <= '0;
      end else begin
         prev_ff       <= prev_in;
         overflow_ff   <= overflow_in;
         index_ff      <= index_in;
         run_start_ff  <= run_start_in;
         run_sum_ff    <= run_sum_in;
         best_start_ff <= best_start_in;
         best_end_ff   <= best_end_in;
         best_len_ff   <= best_len_in;
         best_sum_ff   <= best_sum_in;
      end
   end

   assign best_start  = best_start_ff;
   assign best_end    = best_end_ff;
   assign best_length = best_len_ff;
   assign best_sum    = best_sum_ff;
   assign overflow    = overflow_ff;

endmodule

[hdl/slcl_divider.sv]
// Restoring divider, one quotient bit per cycle, for the cluster mean.
// Depends on slcl_pkg.
`timescale 1ns / 1ps
module slcl_divider #(
   parameter int NUM_W = 27,
   parameter int DEN_W = 12
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   import slcl_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // Shift one dividend bit into the remainder and try a subtract
   always_comb begin
      trial   = {rem_ff, quo_ff[NUM_W-1]};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[hdl/slcl_cordic.sv]
// Rotation-mode CORDIC sine, one iteration per cycle on a shared add/shift unit.
// Depends on slcl_pkg.
`timescale 1ns / 1ps
module slcl_cordic #(
   parameter int ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [19:0] angle,
   output logic               done,
   output logic signed [31:0] sine
);
   import slcl_pkg::*;

   localparam int CNT_W = $clog2(ITERATIONS + 1);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic signed [33:0] x_ff, x_in;
   logic signed [33:0] y_ff, y_in;
   logic signed [33:0] z_ff, z_in;

   logic signed [20:0] a_wide;
   logic signed [20:0] a_wrap;
   logic signed [20:0] a_fold;
   logic signed [33:0] dx;
   logic signed [33:0] dy;
   logic signed [33:0] step_angle;

   // Fold the angle into [-pi/2, pi/2]
   always_comb begin
      a_wide = 21'(angle);
      if (a_wide > PI_Q16) begin
         a_wrap = a_wide - (PI_Q16 <<< 1);
      end else if (a_wide < -PI_Q16) begin
         a_wrap = a_wide + (PI_Q16 <<< 1);
      end else begin
         a_wrap = a_wide;
      end
      if (a_wrap > HALF_PI_Q16) begin
         a_fold = PI_Q16 - a_wrap;
      end else if (a_wrap < -HALF_PI_Q16) begin
         a_fold = -PI_Q16 - a_wrap;
      end else begin
         a_fold = a_wrap;
      end
   end

   // Rotate by one arctangent step
   always_comb begin
      dx         = y_ff >>> cnt_ff;
      dy         = x_ff >>> cnt_ff;
      step_angle = signed'(34'(atan_q30(5'(cnt_ff))));
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         x_in    = CORDIC_GAIN_Q30;
         y_in    = '0;
         z_in    = 34'(a_fold) <<< 14;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - step_angle;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + step_angle;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ITERATIONS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign done = done_ff;
   assign sine = y_ff[31:0];

endmodule

[hdl/scan_longest_cluster_locator.sv]
// Top level of the longest cluster locator: registers, sequencer, result stage.
// Depends on slcl_pkg, the slcl_*_if interfaces, slcl_scan_tracker, slcl_divider,
// slcl_cordic and scan_longest_cluster_locator_macros.svh.
//
//   channel   dir  fields
//   req_chan  in   sample_range[15:0], sample_valid, last_sample
//   rsp_chan  out  found, mean_range[15:0], cluster_angle[19:0], forward_distance[16:0],
//                  truncated
//   csr_chan  in   index[3:0] (0 min, 1 max, 2 start angle, 3 angle step), data[19:0]
//
// Ordinary samples are accepted one per cycle, back to back, while the sequencer is idle.
// A last sample starts the result sequence: close, start, divide, angle multiply,
// angle saturate, sine start, CORDIC sine, distance multiply, distance saturate and
// finish; when no cluster was found it goes from start straight to finish.
// req_chan is held off for the whole sequence; csr_chan is always ready.
// A pending result holds in the output register; a new one waits for it to be taken.
// Reset is synchronous and restores the register defaults and an empty scan.
`timescale 1ns / 1ps
module scan_longest_cluster_locator #(
   parameter int MAX_SAMPLES     = 2048,
   parameter int RANGE_BITS      = 16,
   parameter int SINE_ITERATIONS = 16
) (
   input  logic    clock,
   input  logic    reset,
   slcl_req_if.sink   req_chan,
   slcl_rsp_if.source rsp_chan,
   slcl_csr_if.sink   csr_chan
);
   import slcl_pkg::*;
   `include "scan_longest_cluster_locator_macros.svh"

   localparam int USE_BITS = (RANGE_BITS < 16) ? RANGE_BITS : 16;
   localparam int IDX_W    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W    = USE_BITS + IDX_W;
   localparam int QW       = (SUM_W > 16) ? SUM_W : 16;
   localparam int PW       = IDX_W + 21;
   localparam int AW       = PW + 1;

   // Configuration registers
   logic [15:0]        min_range_ff;
   logic [15:0]        max_range_ff;
   logic signed [19:0] start_angle_ff;
   logic signed [19:0] angle_step_ff;

   state_type state_ff, state_in;

   logic               sample_accept;
   tracker_cmd_type    cmd;
   logic [IDX_W-1:0]   best_start;
   logic [IDX_W-1:0]   best_end;
   logic [IDX_W-1:0]   best_length;
   logic [SUM_W-1:0]   best_sum;
   logic               overflow;

   logic               div_start;
   logic               div_done;
   logic [SUM_W-1:0]   div_quo;
   logic               cordic_start;
   logic               cordic_done;
   logic signed [31:0] sine;
   logic               fin_load;

   logic               found_ff;
   logic [15:0]        mean_ff;
   logic signed [PW-1:0] aprod_ff;
   logic signed [19:0] angle_ff;
   logic signed [48:0] dprod_ff;
   logic signed [16:0] dist_ff;

   logic               rsp_valid_ff;
   logic               rsp_found_ff;
   logic [15:0]        rsp_mean_ff;
   logic signed [19:0] rsp_angle_ff;
   logic signed [16:0] rsp_dist_ff;
   logic               rsp_trunc_ff;

   logic [QW-1:0]      quo_ext;
   logic [15:0]        mean_sat;
   logic [IDX_W:0]     mid_sum;
   logic [IDX_W-1:0]   mid;
   logic signed [AW-1:0] ang_sum;
   logic signed [19:0] ang_sat;
   logic signed [48:0] dadj;
   logic signed [18:0] dquo;
   logic signed [16:0] dist_sat;

   // Register writes; unknown indexes are dropped
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff   <= MIN_RANGE_RESET;
         max_range_ff   <= MAX_RANGE_RESET;
         start_angle_ff <= START_ANGLE_RESET;
         angle_step_ff  <= ANGLE_STEP_RESET;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_MIN_RANGE:   min_range_ff   <= csr_chan.data[15:0];
            CSR_MAX_RANGE:   max_range_ff   <= csr_chan.data[15:0];
            CSR_START_ANGLE: start_angle_ff <= signed'(csr_chan.data);
            CSR_ANGLE_STEP:  angle_step_ff  <= signed'(csr_chan.data);
            default: ;
         endcase
      end
   end

   assign sample_accept = req_chan.valid && req_chan.ready;

   slcl_scan_tracker #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .RANGE_W     (USE_BITS),
      .IDX_W       (IDX_W),
      .SUM_W       (SUM_W)
   ) u_tracker (
      .clock         (clock),
      .reset         (reset),
      .sample_accept (sample_accept),
      .sample_range  (req_chan.sample_range[USE_BITS-1:0]),
      .sample_valid  (req_chan.sample_valid),
      .min_range     (min_range_ff),
      .max_range     (max_range_ff),
      .cmd           (cmd),
      .best_start    (best_start),
      .best_end      (best_end),
      .best_length   (best_length),
      .best_sum      (best_sum),
      .overflow      (overflow)
   );

   slcl_divider #(
      .NUM_W (SUM_W),
      .DEN_W (IDX_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (best_sum),
      .divisor  (best_length),
      .done     (div_done),
      .quotient (div_quo)
   );

   slcl_cordic #(
      .ITERATIONS (SINE_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (angle_ff),
      .done  (cordic_done),
      .sine  (sine)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (sample_accept && req_chan.last_sample) state_in = ST_CLOSE;
         ST_CLOSE:   state_in = ST_START;
         ST_START:   state_in = (best_length != '0) ? ST_DIV : ST_FIN;
         ST_DIV:     if (div_done) state_in = ST_AMUL;
         ST_AMUL:    state_in = ST_ASAT;
         ST_ASAT:    state_in = ST_SINE_GO;
         ST_SINE_GO: state_in = ST_SINE;
         ST_SINE:    if (cordic_done) state_in = ST_DMUL;
         ST_DMUL:    state_in = ST_DSAT;
         ST_DSAT:    state_in = ST_FIN;
         ST_FIN:     if (fin_load) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_chan.ready = (state_ff == ST_IDLE);
      cmd.close      = (state_ff == ST_CLOSE);
      div_start      = (state_ff == ST_START) && (best_length != '0);
      cordic_start   = (state_ff == ST_SINE_GO);
      fin_load       = (state_ff == ST_FIN) && (!rsp_valid_ff || rsp_chan.ready);
      cmd.clear      = fin_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result arithmetic: saturate mean, center angle, distance
   always_comb begin
      quo_ext  = QW'(div_quo);
      mean_sat = (quo_ext > QW'(16'hFFFF)) ? 16'hFFFF : quo_ext[15:0];
      mid_sum  = {1'b0, best_start} + {1'b0, best_end};
      mid      = mid_sum[IDX_W:1];
      ang_sum  = AW'(start_angle_ff) + AW'(aprod_ff);
      if (ang_sum > AW'(ANGLE_LIMIT)) begin
         ang_sat = ANGLE_LIMIT;
      end else if (ang_sum < -AW'(ANGLE_LIMIT)) begin
         ang_sat = -ANGLE_LIMIT;
      end else begin
         ang_sat = ang_sum[19:0];
      end
      // Truncate toward zero: bias negatives before the shift
      dadj = dprod_ff + (dprod_ff[48] ? 49'sd1073741823 : 49'sd0);
      dquo = 19'(dadj >>> 30);
      if (dquo > DIST_LIMIT) begin
         dist_sat = 17'(DIST_LIMIT);
      end else if (dquo < -DIST_LIMIT) begin
         dist_sat = 17'(-DIST_LIMIT);
      end else begin
         dist_sat = dquo[16:0];
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_START) found_ff <= (best_length != '0);
      if ((state_ff == ST_DIV) && div_done) mean_ff <= mean_sat;
      if (state_ff == ST_AMUL) begin
         aprod_ff <= PW'(signed'({1'b0, mid}) * angle_step_ff);
      end
      if (state_ff == ST_ASAT) angle_ff <= ang_sat;
      if (state_ff == ST_DMUL) dprod_ff <= signed'({1'b0, mean_ff}) * sine;
      if (state_ff == ST_DSAT) dist_ff <= dist_sat;
   end

   // Output register: load on finish, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fin_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (fin_load) begin
         rsp_found_ff <= found_ff;
         rsp_mean_ff  <= found_ff ? mean_ff : 16'd0;
         rsp_angle_ff <= found_ff ? angle_ff : 20'sd0;
         rsp_dist_ff  <= found_ff ? dist_ff : 17'sd0;
         rsp_trunc_ff <= overflow;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.found            = rsp_found_ff;
   assign rsp_chan.mean_range       = rsp_mean_ff;
   assign rsp_chan.cluster_angle    = rsp_angle_ff;
   assign rsp_chan.forward_distance = rsp_dist_ff;
   assign rsp_chan.truncated        = rsp_trunc_ff;

   `SLCL_ASSERT_NEXT(a_last_starts_close, clock, reset, sample_accept && req_chan.last_sample, state_ff == ST_CLOSE, "last item did not start the result sequence")
   `SLCL_ASSERT_NOW(a_div_nonzero, clock, reset, div_start, best_length != '0, "divider started with zero length")
   `SLCL_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_mean_ff == 16'd0 && rsp_angle_ff == 20'sd0 && rsp_dist_ff == 17'sd0, "empty result has nonzero fields")
   `SLCL_ASSERT_NOW(a_angle_bound, clock, reset, rsp_valid_ff, rsp_angle_ff <= ANGLE_LIMIT && rsp_angle_ff >= -ANGLE_LIMIT, "center angle out of bounds")

endmodule
